>>> rtl/pgr_pkg.sv
// Shared constants, types and helper functions of the glyph rasterizer.
package pgr_pkg;

	// Glyph geometry and atlas layout
	localparam int unsigned GLYPH_SIZE_DEF = 9;
	localparam int unsigned GLYPHS_PER_ROW = 16;
	localparam int unsigned ATLAS_WIDTH = 256;
	localparam int unsigned ATLAS_ROWS = 64;

	// Atlas store
	localparam int unsigned WORD_W = 64;
	localparam int unsigned MEM_DEPTH = 256;
	localparam int unsigned ADDR_W = 8;
	localparam int unsigned ROW_W = 6;
	localparam int unsigned WSEL_W = 2;

	// Item fields
	localparam int unsigned CODE_W = 8;
	localparam int unsigned PEN_W = 16;
	localparam int unsigned MASK_W = 9;
	localparam int unsigned IN_DATA_W = 88;
	localparam int unsigned OUT_DATA_W = 32;

	// Internal widths
	localparam int unsigned IDX_W = 7;
	localparam int unsigned CELL_W = 5;
	localparam int unsigned LINE_W = 7;
	localparam int unsigned XP_W = 8;
	localparam int unsigned YP_W = 10;
	localparam int unsigned INC_W = 4;

	localparam logic [PEN_W-1:0] PEN_MAX = '1;
	localparam logic [CODE_W-1:0] SPACE_CODE = 8'd32;
	localparam logic [CODE_W-1:0] LAST_CODE = 8'd127;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RENDER = 1'b1;

	typedef struct packed {
		logic start;
		logic [CELL_W-1:0] cell_idx;
		logic [LINE_W-1:0] line;
	} fetch_req_t;

	// Saturating pen advance.
	function automatic logic [PEN_W-1:0] pen_add(input logic [PEN_W-1:0] pen,
			input logic [INC_W-1:0] inc);
		logic [PEN_W:0] sum;
		sum = {1'b0, pen} + {{(PEN_W + 1 - INC_W){1'b0}}, inc};
		return sum[PEN_W] ? PEN_MAX : sum[PEN_W-1:0];
	endfunction

	// Split a glyph index into atlas line (upper bits) and cell (lower bits);
	// the number of glyphs per atlas line is a power of two.
	function automatic logic [LINE_W+CELL_W-1:0] cell_divmod(input logic [IDX_W-1:0] idx);
		return {LINE_W'(idx / GLYPHS_PER_ROW), CELL_W'(idx % GLYPHS_PER_ROW)};
	endfunction

endpackage

>>> rtl/pgr_atlas_mem.sv
// One-bit font atlas store: one write port, one registered read port.
module pgr_atlas_mem (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [pgr_pkg::ADDR_W-1:0]  wr_addr,
	input  logic [pgr_pkg::WORD_W-1:0]  wr_data,
	input  logic                        rd_en,
	input  logic [pgr_pkg::ADDR_W-1:0]  rd_addr,
	output logic [pgr_pkg::WORD_W-1:0]  rd_data
);
	import pgr_pkg::*;

	logic [WORD_W-1:0] mem_q [MEM_DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/pgr_glyph_fetch.sv
// Glyph fetch sequencer: reads two atlas words per glyph row and builds column masks.
module pgr_glyph_fetch #(
	parameter int unsigned GLYPH_SIZE = pgr_pkg::GLYPH_SIZE_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  pgr_pkg::fetch_req_t                      req,
	output logic                                     rd_en,
	output logic [pgr_pkg::ADDR_W-1:0]               rd_addr,
	input  logic [pgr_pkg::WORD_W-1:0]               rd_data,
	output logic                                     done,
	output logic [GLYPH_SIZE-1:0][GLYPH_SIZE-1:0]    cols
);
	import pgr_pkg::*;

	localparam int unsigned CNT_W = $clog2(2 * GLYPH_SIZE);
	localparam int unsigned Y_W = CNT_W - 1;

	logic busy_q;
	logic [CNT_W-1:0] rcnt_q;
	logic [XP_W-1:0] xp0_q;
	logic [YP_W-1:0] yp0_q;
	logic valid_s1, half_s1, rowok_s1;
	logic [Y_W-1:0] y_s1;
	logic [WORD_W-1:0] lo_q;
	logic [GLYPH_SIZE-1:0][GLYPH_SIZE-1:0] cols_q;

	logic [Y_W-1:0] y_iss;
	logic half_iss;
	logic [YP_W-1:0] yp_iss;
	logic rowok_iss;
	logic [WSEL_W-1:0] wsel_iss;
	logic [GLYPH_SIZE-1:0] colok;
	logic [GLYPH_SIZE-1:0] row_bits;

	// Issue side: even reads fetch the glyph's first word, odd reads the next one.
	always_comb begin
		y_iss = rcnt_q[CNT_W-1:1];
		half_iss = rcnt_q[0];
		yp_iss = yp0_q + YP_W'(y_iss);
		rowok_iss = (yp_iss < YP_W'(ATLAS_ROWS)) && (yp_iss < YP_W'(64));
		wsel_iss = xp0_q[XP_W-1:XP_W-WSEL_W] + WSEL_W'(half_iss);
	end

	assign rd_en = busy_q;
	assign rd_addr = {yp_iss[ROW_W-1:0], wsel_iss};

	// Return side: pick each column's pixel out of the two words.
	always_comb begin
		logic [6:0] pos;
		for (int x = 0; x < GLYPH_SIZE; x++) begin
			pos = 7'(xp0_q[5:0]) + 7'(x);
			colok[x] = ({1'b0, xp0_q} + 9'(x)) < 9'(ATLAS_WIDTH);
			row_bits[x] = (pos[6] ? rd_data[pos[5:0]] : lo_q[pos[5:0]])
					& colok[x] & rowok_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rcnt_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= busy_q;
			if (req.start) begin
				busy_q <= 1'b1;
				rcnt_q <= '0;
			end else if (busy_q) begin
				rcnt_q <= rcnt_q + CNT_W'(1);
				if (rcnt_q == CNT_W'(2 * GLYPH_SIZE - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			xp0_q <= XP_W'(req.cell_idx) * XP_W'(GLYPH_SIZE + 1);
			yp0_q <= YP_W'(req.line) * YP_W'(GLYPH_SIZE + 1) + YP_W'(1);
		end
		half_s1 <= half_iss;
		y_s1 <= y_iss;
		rowok_s1 <= rowok_iss;
		if (valid_s1 && !half_s1) begin
			lo_q <= rd_data;
		end
		if (valid_s1 && half_s1) begin
			for (int x = 0; x < GLYPH_SIZE; x++) begin
				cols_q[x][y_s1] <= row_bits[x];
			end
		end
	end

	assign done = valid_s1 && half_s1 && (y_s1 == Y_W'(GLYPH_SIZE - 1));
	assign cols = cols_q;

endmodule

>>> rtl/proportional_glyph_rasterizer_core.sv
// Proportional glyph rasterizer top level: handshakes, sequencing, pen and output register.
// Load transaction: written to the atlas at acceptance, ready stays high, no result.
// Render of space or an ignored code: ready stays high, no result.
// Render of a glyph: ready drops after acceptance until the glyph is done, output stalls
// included; two atlas reads per glyph row, then the columns are scanned in order.
// Reset clears the pen and all control state; atlas contents stay undefined until loaded.
module proportional_glyph_rasterizer_core #(
	parameter int unsigned GLYPH_SIZE = pgr_pkg::GLYPH_SIZE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// tdata: start_text[0], char_code[8:1], atlas_row[14:9], atlas_word[16:15],
	//        atlas_bits[80:17], zero fill above
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [pgr_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// tuser: operation[0]
	input  logic                                s_axis_tuser,
	// tdata: pen_x[15:0], column_mask[24:16], zero fill above
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [pgr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// tlast: last_column
	output logic                                m_axis_tlast
);
	import pgr_pkg::*;

	localparam int unsigned COL_W = $clog2(GLYPH_SIZE);
	localparam int unsigned LIT_W = $clog2(GLYPH_SIZE + 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_START  = 5'b00100,
		S_FETCH  = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	state_t state_q;
	logic [PEN_W-1:0] pen_q;
	logic [IDX_W-1:0] idx_q;
	logic [CELL_W-1:0] cell_q;
	logic [LINE_W-1:0] line_q;
	logic [COL_W-1:0] colx_q;
	logic [LIT_W-1:0] lit_q;
	logic out_valid_q;
	logic [PEN_W-1:0] out_pen_q;
	logic [MASK_W-1:0] out_mask_q;
	logic out_last_q;

	// Input field unpacking
	logic in_start;
	logic [CODE_W-1:0] in_code;
	logic [ROW_W-1:0] in_row;
	logic [WSEL_W-1:0] in_word;
	logic [WORD_W-1:0] in_bits;

	assign in_start = s_axis_tdata[0];
	assign in_code = s_axis_tdata[8:1];
	assign in_row = s_axis_tdata[14:9];
	assign in_word = s_axis_tdata[16:15];
	assign in_bits = s_axis_tdata[80:17];

	logic in_fire;
	logic load_ok;
	logic [PEN_W-1:0] pen_base;
	logic [LINE_W+CELL_W-1:0] divmod;

	fetch_req_t fetch_req;
	logic rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic fetch_done;
	logic [GLYPH_SIZE-1:0][GLYPH_SIZE-1:0] cols;

	// Emit-side signals
	logic slot_free;
	logic emit_col;
	logic [GLYPH_SIZE-1:0] col_cur;
	logic col_lit;
	logic [GLYPH_SIZE-1:0] later_lit;
	logic [LIT_W-1:0] lit_next;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire = s_axis_tvalid && s_axis_tready;

	// Drop loads that fall outside the configured atlas.
	assign load_ok = ({1'b0, in_word, 6'b0} < 9'(ATLAS_WIDTH))
			&& ({3'b0, in_row} < 9'(ATLAS_ROWS));

	assign pen_base = in_start ? '0 : pen_q;
	assign divmod = cell_divmod(idx_q);

	assign fetch_req.start = (state_q == S_START);
	assign fetch_req.cell_idx = cell_q;
	assign fetch_req.line = line_q;

	pgr_atlas_mem u_atlas (
		.clk     (clk),
		.wr_en   (in_fire && (s_axis_tuser == OP_LOAD) && load_ok),
		.wr_addr ({in_row, in_word}),
		.wr_data (in_bits),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pgr_glyph_fetch #(
		.GLYPH_SIZE (GLYPH_SIZE)
	) u_fetch (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (fetch_req),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.done    (fetch_done),
		.cols    (cols)
	);

	// The output register frees when empty or when its transaction completes.
	assign slot_free = !out_valid_q || m_axis_tready;
	assign col_cur = cols[colx_q];
	assign col_lit = |col_cur;
	assign lit_next = lit_q + LIT_W'(col_lit);
	// Load a lit column into the output register.
	assign emit_col = (state_q == S_EMIT) && slot_free && col_lit;

	// Flag, per column, whether any column to its right is lit.
	always_comb begin
		for (int x = 0; x < GLYPH_SIZE; x++) begin
			later_lit[x] = 1'b0;
			for (int j = 0; j < GLYPH_SIZE; j++) begin
				if (j > x) begin
					later_lit[x] = later_lit[x] | (|cols[j]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pen_q <= '0;
			colx_q <= '0;
			lit_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Hold the pending column until its transaction completes.
			if (emit_col) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire && (s_axis_tuser == OP_RENDER)) begin
						if (in_code == SPACE_CODE) begin
							pen_q <= pen_add(pen_base, INC_W'(GLYPH_SIZE));
						end else if ((in_code > SPACE_CODE) && (in_code <= LAST_CODE)) begin
							pen_q <= pen_base;
							state_q <= S_DECODE;
						end else begin
							// Ignore the code but honor the pen restart.
							pen_q <= pen_base;
						end
					end
				end
				S_DECODE: begin
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					if (fetch_done) begin
						colx_q <= '0;
						lit_q <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						lit_q <= lit_next;
						colx_q <= colx_q + COL_W'(1);
						if (colx_q == COL_W'(GLYPH_SIZE - 1)) begin
							// Advance the pen past the lit columns plus one gap.
							pen_q <= pen_add(pen_q, INC_W'(lit_next) + INC_W'(1));
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: glyph index, cell split and the pending column.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			idx_q <= IDX_W'(in_code - SPACE_CODE);
		end
		if (state_q == S_DECODE) begin
			line_q <= divmod[LINE_W+CELL_W-1:CELL_W];
			cell_q <= divmod[CELL_W-1:0];
		end
		if (emit_col) begin
			out_pen_q <= pen_add(pen_q, INC_W'(lit_q));
			out_mask_q <= MASK_W'(col_cur);
			out_last_q <= !later_lit[colx_q];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(OUT_DATA_W - PEN_W - MASK_W){1'b0}}, out_mask_q, out_pen_q};
	assign m_axis_tlast = out_last_q;

endmodule

>>> tb/glyph_column_checker.sv
// Scoreboard for the glyph rasterizer: predicts emitted glyph columns and checks the output stream.
module glyph_column_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	// tdata: start_text, char_code, atlas_row, atlas_word, atlas_bits, zero fill
	input  logic [pgr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// tuser: operation
	input  logic                            s_axis_tuser,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tdata: pen_x, column_mask, zero fill
	input  logic [pgr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                            m_axis_tlast,
	output int unsigned                     mismatch_count,
	output int unsigned                     columns_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import pgr_pkg::*;

	localparam int unsigned GLYPH = GLYPH_SIZE_DEF;
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct packed {
		logic [PEN_W-1:0]  pen_x;
		logic [MASK_W-1:0] mask;
		logic              last;
	} column_t;

	logic [WORD_W-1:0] glyph_atlas [MEM_DEPTH];
	logic [PEN_W-1:0]  pen;
	column_t           expected_columns [$];
	int unsigned       error_tally = 0;
	int unsigned       pending_tally = 0;

	assign mismatch_count = error_tally;
	assign columns_pending = pending_tally;

	function automatic logic [PEN_W-1:0] saturate_pen(input int unsigned value);
		return (value > PEN_MAX) ? PEN_MAX : value[PEN_W-1:0];
	endfunction

	// Pixels outside the atlas read as unlit.
	function automatic logic atlas_pixel(input int unsigned xp, input int unsigned yp);
		if (xp >= ATLAS_WIDTH || yp >= ATLAS_ROWS || yp >= 64)
			return 1'b0;
		return glyph_atlas[(yp * 4 + xp / 64) % MEM_DEPTH][xp % 64];
	endfunction

	task automatic rasterize_glyph(input logic [CODE_W-1:0] code);
		int unsigned       idx;
		int unsigned       base_x;
		int unsigned       base_y;
		int unsigned       lit;
		int unsigned       final_col;
		int                x;
		int                y;
		logic [MASK_W-1:0] masks [GLYPH];
		column_t           col;
		idx = int'(code) - int'(SPACE_CODE);
		base_x = (idx % GLYPHS_PER_ROW) * (GLYPH + 1);
		base_y = (idx / GLYPHS_PER_ROW) * (GLYPH + 1) + 1;
		lit = 0;
		final_col = 0;
		for (x = 0; x < GLYPH; x++) begin
			masks[x] = '0;
			for (y = 0; y < GLYPH; y++)
				masks[x][y] = atlas_pixel(base_x + x, base_y + y);
			if (masks[x] != '0)
				final_col = x;
		end
		for (x = 0; x < GLYPH; x++) begin
			if (masks[x] != '0) begin
				col.pen_x = saturate_pen(pen + lit);
				col.mask = masks[x];
				col.last = (x == final_col);
				expected_columns.push_back(col);
				lit++;
			end
		end
		pen = saturate_pen(pen + lit + 1);
	endtask

	task automatic accept_item(input logic op, input logic [IN_DATA_W-1:0] data);
		logic              start;
		logic [CODE_W-1:0] code;
		logic [ROW_W-1:0]  row;
		logic [WSEL_W-1:0] word;
		logic [WORD_W-1:0] bits;
		start = data[0];
		code = data[8:1];
		row = data[14:9];
		word = data[16:15];
		bits = data[80:17];
		if (op == OP_LOAD) begin
			if (int'(word) * 64 < ATLAS_WIDTH && int'(row) < ATLAS_ROWS)
				glyph_atlas[{row, word}] = bits;
		end else begin
			if (start)
				pen = '0;
			if (code == SPACE_CODE)
				pen = saturate_pen(pen + GLYPH);
			else if (code > SPACE_CODE && code <= LAST_CODE)
				rasterize_glyph(code);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		column_t got;
		column_t want;
		if (!arst_n) begin
			pen = '0;
			expected_columns.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.pen_x = m_axis_tdata[15:0];
				got.mask = m_axis_tdata[24:16];
				got.last = m_axis_tlast;
				if (expected_columns.size() == 0) begin
					if (error_tally < MAX_REPORTS)
						$display("ERROR: unexpected column pen_x=%0d mask=%03h last=%0b",
							got.pen_x, got.mask, got.last);
					error_tally++;
				end else begin
					want = expected_columns.pop_front();
					if (got !== want) begin
						if (error_tally < MAX_REPORTS)
							$display({"ERROR: column mismatch: expected pen_x=%0d mask=%03h ",
								"last=%0b, got pen_x=%0d mask=%03h last=%0b"},
								want.pen_x, want.mask, want.last,
								got.pen_x, got.mask, got.last);
						error_tally++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				accept_item(s_axis_tuser, s_axis_tdata);
		end
		pending_tally = expected_columns.size();
	end

endmodule

>>> tb/tb_proportional_glyph_rasterizer_core.sv
// Testbench top for the glyph rasterizer: drives load and render traffic and reports the verdict.
module tb_proportional_glyph_rasterizer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import pgr_pkg::*;

	// Watchdog: cycles with no transaction on either channel before giving up
	localparam int unsigned IDLE_LIMIT = 1000;
	localparam int unsigned RANDOM_ITEMS = 120;
	// Quiet cycles after the last result
	localparam int unsigned DRAIN_CYCLES = 64;

	// Printable codes used by the directed part
	localparam logic [CODE_W-1:0] CODE_BANG = 8'd33;   // cell 1, lit solid at load
	localparam logic [CODE_W-1:0] CODE_QUOTE = 8'd34;  // cell 2, lit solid at load
	localparam logic [CODE_W-1:0] CODE_AMP = 8'd38;    // cell 6, straddles two words
	localparam logic [CODE_W-1:0] CODE_ZERO = 8'd48;   // line 1 cell 0, blank at load

	typedef enum {SINK_OPEN, SINK_RANDOM, SINK_CHOKED} sink_mode_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// tdata: start_text[0], char_code[8:1], atlas_row[14:9], atlas_word[16:15],
	//        atlas_bits[80:17], zero fill above
	logic [IN_DATA_W-1:0]   s_axis_tdata;
	// tuser: operation[0]
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// tdata: pen_x[15:0], column_mask[24:16], zero fill above
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic                   m_axis_tlast;

	int unsigned            mismatch_count;
	int unsigned            columns_pending;
	int unsigned            burst_left = 1;

	proportional_glyph_rasterizer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	glyph_column_checker scoreboard (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tlast    (m_axis_tlast),
		.mismatch_count  (mismatch_count),
		.columns_pending (columns_pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Mix of solid words, blank words, sparse and dense random words, so that
	// glyphs come out with every count of lit columns.
	function automatic logic [WORD_W-1:0] atlas_pattern();
		logic [WORD_W-1:0] dense;
		dense = {$urandom, $urandom};
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return dense & {$urandom, $urandom} & {$urandom, $urandom};
			default: return dense;
		endcase
	endfunction

	// Present one transaction at the falling edge, hold it until accepted, then
	// close the burst with a random gap when its length runs out. One burst in
	// four carries no gap, which gives long back-to-back stretches.
	task automatic issue_item(input logic op, input logic start, input logic [CODE_W-1:0] code,
			input logic [ROW_W-1:0] row, input logic [WSEL_W-1:0] word,
			input logic [WORD_W-1:0] bits);
		int unsigned gap;
		s_axis_tuser <= op;
		s_axis_tdata <= {{(IN_DATA_W - 81){1'b0}}, bits, word, row, code, start};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Render with random filler in the load fields, which the block must ignore.
	task automatic render_char(input logic start, input logic [CODE_W-1:0] code);
		issue_item(OP_RENDER, start, code, ROW_W'($urandom), WSEL_W'($urandom),
			{$urandom, $urandom});
	endtask

	// Hold the sender off until every predicted column has come out.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (columns_pending != 0);
	endtask

	// Receiver: switch between always ready, coin-flip ready and a choked sink
	// over spans of random length, so stalls land on every output phase.
	initial begin : sink_stall
		sink_mode_t  mode;
		int unsigned span;
		m_axis_tready = 1'b0;
		mode = SINK_OPEN;
		span = 0;
		forever begin
			@(negedge clk);
			if (span == 0) begin
				mode = sink_mode_t'($urandom_range(0, 2));
				span = $urandom_range(20, 200);
			end
			span--;
			case (mode)
				SINK_OPEN: m_axis_tready <= 1'b1;
				SINK_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Watchdog: end the run when nothing moves on either channel for too long.
	initial begin : watchdog
		int unsigned idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		logic [WORD_W-1:0] bits;
		logic [CODE_W-1:0] code;
		int unsigned       pick;
		int                r;
		int                w;
		int unsigned       i;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_LOAD;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Fill the whole atlas first so no render ever reads an unwritten word.
		// Word 0 of rows 1..9 is solid (cells 0..5 of line 0 fully lit, cell 6
		// lit on its left part); word 0 of rows 11..19 is blank (cells 0..5 of
		// line 1 draw nothing).
		for (r = 0; r < ATLAS_ROWS; r++) begin
			for (w = 0; w < 4; w++) begin
				if (w == 0 && r >= 1 && r <= 9)
					bits = '1;
				else if (w == 0 && r >= 11 && r <= 19)
					bits = '0;
				else
					bits = atlas_pattern();
				issue_item(OP_LOAD, 1'($urandom), CODE_W'($urandom), ROW_W'(r),
					WSEL_W'(w), bits);
			end
		end

		// Directed part: full glyphs, blank glyph, space, both ends of the
		// printable range, codes that are ignored, and pen resets.
		render_char(1'b1, CODE_BANG);
		render_char(1'b0, CODE_QUOTE);
		render_char(1'b0, SPACE_CODE);
		render_char(1'b0, CODE_ZERO);
		render_char(1'b0, 8'd0);
		render_char(1'b0, 8'd31);
		render_char(1'b0, LAST_CODE);
		render_char(1'b0, 8'd128);
		render_char(1'b0, 8'd255);
		render_char(1'b0, CODE_AMP);
		render_char(1'b1, 8'd200);
		render_char(1'b0, CODE_BANG);
		// Loads carry start_text and char_code too; the pen must stay put.
		issue_item(OP_LOAD, 1'b1, CODE_BANG, ROW_W'(63), WSEL_W'(3), '1);
		issue_item(OP_LOAD, 1'b1, 8'd255, ROW_W'(0), WSEL_W'(0), '0);
		render_char(1'b0, CODE_QUOTE);
		render_char(1'b0, 8'd33 + 8'($urandom_range(0, 94)));
		drain_results();

		// Random part: mostly printable renders over a shifting atlas, with some
		// spaces, stray codes, pen resets and now and then a full drain.
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				issue_item(OP_LOAD, 1'($urandom), CODE_W'($urandom), ROW_W'($urandom),
					WSEL_W'($urandom), atlas_pattern());
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					code = CODE_W'($urandom_range(33, 127));
				else if (pick < 82)
					code = SPACE_CODE;
				else
					code = CODE_W'($urandom);
				render_char($urandom_range(0, 4) == 0, code);
			end
			if ($urandom_range(0, 29) == 0)
				drain_results();
		end

		// Wait out every predicted column, then let the block settle.
		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
